FILE: rtl/mvgt_pkg.sv
package mvgt_pkg;

  localparam logic [7:0] NOTE_ON     = 8'h90;
  localparam int         MAX_RESULTS = 32;
  localparam int         QW          = 5;

  localparam logic [1:0] OP_PLAY  = 2'd0;
  localparam logic [1:0] OP_CHORD = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [7:0] OFS_MINOR   = 8'd3;
  localparam logic [7:0] OFS_MAJOR   = 8'd4;
  localparam logic [7:0] OFS_FIFTH   = 8'd7;
  localparam logic [7:0] OFS_SEVENTH = 8'd10;
  localparam logic [7:0] NOTE_MAX    = 8'd127;

  localparam logic [3:0] IV_MINOR = 4'd3;
  localparam logic [3:0] IV_MAJOR = 4'd4;
  localparam logic [3:0] IV_FIFTH = 4'd7;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  channel;
    logic [6:0]  key_number;
    logic [15:0] gate_ticks;
    logic [6:0]  velocity;
    logic        minor_chord;
    logic        add_seventh;
    logic [15:0] elapsed_ticks;
  } in_t;

  typedef struct packed {
    logic        message_valid;
    logic [7:0]  status_byte;
    logic [6:0]  data_first;
    logic [6:0]  data_second;
    logic [6:0]  chord_root;
    logic        root_found;
    logic        chord_is_minor;
    logic        quality_found;
    logic        table_overflow;
    logic        last_result;
  } out_t;

  typedef enum logic [4:0] {
    C_NONE, C_ACCEPT, C_NEXT, C_FIND_RD, C_FIND_MISS, C_FIND_HIT, C_RMV_RD,
    C_RMV_WR, C_RMV_END, C_APPEND, C_TRD, C_TCHK, C_TEND, C_SA_RD, C_SA_LD,
    C_SB_RD, C_SB_EVAL, C_SA_NEXT, C_Q_INIT, C_Q_RD, C_Q_OUT, C_QUIET
  } dp_cmd_t;

  typedef struct packed {
    logic start_chain;
    logic start_tick;
    logic mask_empty;
    logic idx_lt_cnt;
    logic idx1_lt_cnt;
    logic j_lt_cnt;
    logic hit;
    logic k_lt_q;
    logic q_empty;
  } dp_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_NEXT, ST_FIND, ST_FCHK, ST_RMV, ST_RMVW, ST_APPEND, ST_TRD,
    ST_TCHK, ST_SA, ST_SAW, ST_SB, ST_SBW, ST_QRD, ST_QOUT, ST_QUIET
  } ctl_state_t;

  function automatic logic [3:0] mod12(input logic [6:0] d);
    logic [14:0] p;
    logic [3:0]  q;
    logic [6:0]  r;
    p = 15'(d) * 15'd171;
    q = p[14:11];
    r = d - 7'(q * 7'd12);
    return r[3:0];
  endfunction

endpackage

FILE: rtl/mvgt_datapath.sv
module mvgt_datapath #(
  parameter int VOICES = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mvgt_pkg::dp_cmd_t  cmd,
  input  mvgt_pkg::in_t      in_item,
  output mvgt_pkg::dp_stat_t stat,
  output logic               out_valid,
  output mvgt_pkg::out_t     out_item
);
  import mvgt_pkg::*;

  localparam int CW = $clog2(VOICES + 1);
  localparam int AW = $clog2(VOICES);

  typedef struct packed {
    logic [3:0]         channel;
    logic [6:0]         note;
    logic signed [16:0] gate;
  } voice_t;

  typedef struct packed {
    logic [3:0] channel;
    logic [6:0] note;
  } qent_t;

  voice_t vmem [VOICES];
  qent_t  qmem [MAX_RESULTS];
  voice_t mem_q;
  qent_t  qmem_q;

  in_t         item_r, item_nxt;
  logic [3:0]  mask_r, mask_nxt;
  logic [6:0]  note_r, note_nxt;
  logic        last_r, last_nxt;
  logic [CW-1:0] idx_r, idx_nxt, jdx_r, jdx_nxt, cnt_r, cnt_nxt;
  logic [6:0]  a_r, a_nxt;
  logic [QW:0] qn_r, qn_nxt, qk_r, qk_nxt;
  logic [6:0]  root_r, root_nxt;
  logic        rootv_r, rootv_nxt, minor_r, minor_nxt, minv_r, minv_nxt;
  logic        ov_r, ov_nxt, mv_r, mv_nxt, ovf_r, ovf_nxt, lst_r, lst_nxt;
  logic [7:0]  sb_r, sb_nxt;
  logic [6:0]  d1_r, d1_nxt, d2_r, d2_nxt;

  logic [CW-1:0] idx1;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          we, qwe;
  voice_t        wd;
  logic [7:0]    n1, n2, n3;
  logic [3:0]    in_mask;
  logic [7:0]    pick;
  logic [3:0]    mask_rest;
  logic signed [17:0] g;
  logic          expire;
  logic [6:0]    diff;
  logic [3:0]    iv;

  assign idx1 = idx_r + CW'(1);
  assign n1 = {1'b0, in_item.key_number} + (in_item.minor_chord ? OFS_MINOR : OFS_MAJOR);
  assign n2 = {1'b0, in_item.key_number} + OFS_FIFTH;
  assign n3 = {1'b0, in_item.key_number} + OFS_SEVENTH;

  always_comb begin
    in_mask = 4'b0000;
    if (in_item.operation == OP_PLAY) begin
      in_mask = 4'b0001;
    end else if (in_item.operation == OP_CHORD) begin
      in_mask = {in_item.add_seventh && (n3 <= NOTE_MAX), n2 <= NOTE_MAX,
                 n1 <= NOTE_MAX, 1'b1};
    end
  end

  assign g = 18'(mem_q.gate) - $signed({2'b00, item_r.elapsed_ticks});
  assign expire = (g <= 18'sd0) && (qn_r < (QW+1)'(MAX_RESULTS));
  assign diff = mem_q.note - a_r;
  assign iv = mod12(diff);

  always_comb begin
    pick = {1'b0, item_r.key_number};
    mask_rest = mask_r;
    priority if (mask_r[0]) begin
      mask_rest[0] = 1'b0;
    end else if (mask_r[1]) begin
      pick = pick + (item_r.minor_chord ? OFS_MINOR : OFS_MAJOR);
      mask_rest[1] = 1'b0;
    end else if (mask_r[2]) begin
      pick = pick + OFS_FIFTH;
      mask_rest[2] = 1'b0;
    end else begin
      pick = pick + OFS_SEVENTH;
      mask_rest[3] = 1'b0;
    end
  end

  assign stat.start_chain = (in_mask != 4'b0000);
  assign stat.start_tick  = (in_item.operation == OP_TICK);
  assign stat.mask_empty  = (mask_r == 4'b0000);
  assign stat.idx_lt_cnt  = (idx_r < cnt_r);
  assign stat.idx1_lt_cnt = (idx1 < cnt_r);
  assign stat.j_lt_cnt    = (jdx_r < cnt_r);
  assign stat.hit         = (mem_q.channel == item_r.channel) && (mem_q.note == note_r);
  assign stat.k_lt_q      = (qk_r < qn_r);
  assign stat.q_empty     = (qn_r == '0);

  always_comb begin
    item_nxt = item_r;  mask_nxt = mask_r;  note_nxt = note_r;  last_nxt = last_r;
    idx_nxt = idx_r;    jdx_nxt = jdx_r;    cnt_nxt = cnt_r;    a_nxt = a_r;
    qn_nxt = qn_r;      qk_nxt = qk_r;
    root_nxt = root_r;  rootv_nxt = rootv_r; minor_nxt = minor_r; minv_nxt = minv_r;
    ov_nxt = 1'b0;      mv_nxt = mv_r;      sb_nxt = sb_r;      d1_nxt = d1_r;
    d2_nxt = d2_r;      ovf_nxt = ovf_r;    lst_nxt = lst_r;
    rd_addr = idx_r[AW-1:0];
    wr_addr = idx_r[AW-1:0];
    we = 1'b0;
    qwe = 1'b0;
    wd = mem_q;
    unique case (cmd)
      C_NONE: ;
      C_ACCEPT: begin
        item_nxt = in_item;
        mask_nxt = in_mask;
        idx_nxt = '0;
        jdx_nxt = '0;
        qn_nxt = '0;
      end
      C_NEXT: begin
        note_nxt = pick[6:0];
        mask_nxt = mask_rest;
        last_nxt = (mask_rest == 4'b0000);
        idx_nxt = '0;
      end
      C_FIND_RD: ;
      C_FIND_MISS: idx_nxt = idx1;
      C_FIND_HIT: begin
        ov_nxt = 1'b1;  mv_nxt = 1'b1;  sb_nxt = NOTE_ON | {4'h0, item_r.channel};
        d1_nxt = note_r; d2_nxt = '0;   ovf_nxt = 1'b0;     lst_nxt = 1'b0;
      end
      C_RMV_RD: rd_addr = idx1[AW-1:0];
      C_RMV_WR: begin
        we = 1'b1;
        idx_nxt = idx1;
      end
      C_RMV_END: cnt_nxt = cnt_r - CW'(1);
      C_APPEND: begin
        ov_nxt = 1'b1;  mv_nxt = 1'b1;  sb_nxt = NOTE_ON | {4'h0, item_r.channel};
        d1_nxt = note_r; d2_nxt = item_r.velocity; lst_nxt = last_r;
        ovf_nxt = (cnt_r >= CW'(VOICES));
        wr_addr = cnt_r[AW-1:0];
        wd = '{channel: item_r.channel, note: note_r,
               gate: $signed({1'b0, item_r.gate_ticks})};
        if (cnt_r < CW'(VOICES)) begin
          we = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      C_TRD: ;
      C_TCHK: begin
        idx_nxt = idx1;
        if (expire) begin
          qwe = 1'b1;
          qn_nxt = qn_r + (QW+1)'(1);
        end else begin
          we = 1'b1;
          wr_addr = jdx_r[AW-1:0];
          wd.gate = (g < 18'sd0) ? 17'sd0 : g[16:0];
          jdx_nxt = jdx_r + CW'(1);
        end
      end
      C_TEND: begin
        cnt_nxt = jdx_r;
        idx_nxt = '0;
        root_nxt = '0; rootv_nxt = 1'b0; minor_nxt = 1'b0; minv_nxt = 1'b0;
      end
      C_SA_RD: ;
      C_SA_LD: begin
        a_nxt = mem_q.note;
        jdx_nxt = '0;
      end
      C_SB_RD: rd_addr = jdx_r[AW-1:0];
      C_SB_EVAL: begin
        jdx_nxt = jdx_r + CW'(1);
        if (mem_q.note > a_r) begin
          if (iv == IV_MINOR) begin
            minv_nxt = 1'b1; minor_nxt = 1'b1;
          end else if (iv == IV_MAJOR) begin
            minv_nxt = 1'b1; minor_nxt = 1'b0;
          end else if (iv == IV_FIFTH) begin
            rootv_nxt = 1'b1; root_nxt = a_r;
          end
        end
      end
      C_SA_NEXT: idx_nxt = idx1;
      C_Q_INIT: qk_nxt = '0;
      C_Q_RD: ;
      C_Q_OUT: begin
        ov_nxt = 1'b1;  mv_nxt = 1'b1;  sb_nxt = NOTE_ON | {4'h0, qmem_q.channel};
        d1_nxt = qmem_q.note; d2_nxt = '0; ovf_nxt = 1'b0;
        lst_nxt = (qk_r + (QW+1)'(1) == qn_r);
        qk_nxt = qk_r + (QW+1)'(1);
      end
      C_QUIET: begin
        ov_nxt = 1'b1;  mv_nxt = 1'b0;  sb_nxt = '0;
        d1_nxt = '0;    d2_nxt = '0;    ovf_nxt = 1'b0;  lst_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      vmem[wr_addr] <= wd;
    end
    mem_q <= vmem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (qwe) begin
      qmem[qn_r[QW-1:0]] <= '{channel: mem_q.channel, note: mem_q.note};
    end
    qmem_q <= qmem[qk_r[QW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      root_r <= '0; rootv_r <= 1'b0; minor_r <= 1'b0; minv_r <= 1'b0;
      ov_r <= 1'b0;
      qn_r <= '0;
      qk_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      root_r <= root_nxt; rootv_r <= rootv_nxt; minor_r <= minor_nxt; minv_r <= minv_nxt;
      ov_r <= ov_nxt;
      qn_r <= qn_nxt;
      qk_r <= qk_nxt;
    end
    item_r <= item_nxt; mask_r <= mask_nxt; note_r <= note_nxt; last_r <= last_nxt;
    idx_r <= idx_nxt;   jdx_r <= jdx_nxt;   a_r <= a_nxt;
    mv_r <= mv_nxt; sb_r <= sb_nxt; d1_r <= d1_nxt; d2_r <= d2_nxt;
    ovf_r <= ovf_nxt; lst_r <= lst_nxt;
  end

  assign out_valid = ov_r;
  assign out_item = '{message_valid: mv_r, status_byte: sb_r, data_first: d1_r,
                      data_second: d2_r, chord_root: root_r, root_found: rootv_r,
                      chord_is_minor: minor_r, quality_found: minv_r,
                      table_overflow: ovf_r, last_result: lst_r};

endmodule

FILE: rtl/mvgt_ctrl.sv
module mvgt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  mvgt_pkg::dp_stat_t stat,
  output mvgt_pkg::dp_cmd_t  cmd,
  output logic               busy
);
  import mvgt_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = C_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd = C_ACCEPT;
          priority if (stat.start_tick) state_nxt = ST_TRD;
          else if (stat.start_chain) state_nxt = ST_NEXT;
          else state_nxt = ST_QUIET;
        end
      end
      ST_NEXT: begin
        if (stat.mask_empty) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd = C_NEXT;
          state_nxt = ST_FIND;
        end
      end
      ST_FIND: begin
        if (stat.idx_lt_cnt) begin
          cmd = C_FIND_RD;
          state_nxt = ST_FCHK;
        end else begin
          state_nxt = ST_APPEND;
        end
      end
      ST_FCHK: begin
        if (stat.hit) begin
          cmd = C_FIND_HIT;
          state_nxt = ST_RMV;
        end else begin
          cmd = C_FIND_MISS;
          state_nxt = ST_FIND;
        end
      end
      ST_RMV: begin
        if (stat.idx1_lt_cnt) begin
          cmd = C_RMV_RD;
          state_nxt = ST_RMVW;
        end else begin
          cmd = C_RMV_END;
          state_nxt = ST_APPEND;
        end
      end
      ST_RMVW: begin
        cmd = C_RMV_WR;
        state_nxt = ST_RMV;
      end
      ST_APPEND: begin
        cmd = C_APPEND;
        state_nxt = stat.mask_empty ? ST_IDLE : ST_NEXT;
      end
      ST_TRD: begin
        if (stat.idx_lt_cnt) begin
          cmd = C_TRD;
          state_nxt = ST_TCHK;
        end else begin
          cmd = C_TEND;
          state_nxt = ST_SA;
        end
      end
      ST_TCHK: begin
        cmd = C_TCHK;
        state_nxt = ST_TRD;
      end
      ST_SA: begin
        if (stat.idx_lt_cnt) begin
          cmd = C_SA_RD;
          state_nxt = ST_SAW;
        end else begin
          cmd = C_Q_INIT;
          state_nxt = ST_QRD;
        end
      end
      ST_SAW: begin
        cmd = C_SA_LD;
        state_nxt = ST_SB;
      end
      ST_SB: begin
        if (stat.j_lt_cnt) begin
          cmd = C_SB_RD;
          state_nxt = ST_SBW;
        end else begin
          cmd = C_SA_NEXT;
          state_nxt = ST_SA;
        end
      end
      ST_SBW: begin
        cmd = C_SB_EVAL;
        state_nxt = ST_SB;
      end
      ST_QRD: begin
        priority if (stat.q_empty) begin
          cmd = C_QUIET;
          state_nxt = ST_IDLE;
        end else if (stat.k_lt_q) begin
          cmd = C_Q_RD;
          state_nxt = ST_QOUT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_QOUT: begin
        cmd = C_Q_OUT;
        state_nxt = ST_QRD;
      end
      ST_QUIET: begin
        cmd = C_QUIET;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

FILE: rtl/midi_voice_gate_tracker.sv
// Tracks up to VOICES sounding MIDI voices in insertion order. An item is
// taken when start is high and busy is low; its beats then appear on out_item,
// each for one cycle with out_valid, the final one marked by last_result, and
// the receiver cannot stall them. A play item searches the stored voices one at
// a time and shifts the later voices down on removal; a tick ages the table,
// scans every ordered pair of the remaining voices for chord intervals, then
// emits the expired notes as note-offs. The search, shift, ageing and scan read
// the voices through the single read port of the voice memory.
module midi_voice_gate_tracker #(
  parameter int VOICES = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  mvgt_pkg::in_t  in_item,
  output logic           out_valid,
  output mvgt_pkg::out_t out_item
);
  import mvgt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mvgt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  mvgt_datapath #(.VOICES(VOICES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

FILE: rtl/mvgt_checker.sv
module mvgt_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input mvgt_pkg::out_t out_item
);
  import mvgt_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accepted beat");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last_result |=> !out_valid)
    else $error("beat right after final beat");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last_result |-> busy)
    else $error("idle before final beat");

  a_quiet_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.message_valid |->
      out_item.status_byte == 8'h00 && out_item.last_result)
    else $error("quiet beat carries data");

  a_note_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.message_valid |-> out_item.status_byte[7:4] == NOTE_ON[7:4])
    else $error("bad status byte");

endmodule

bind midi_voice_gate_tracker mvgt_checker u_chk (.*);

FILE: dv/midi_voice_gate_tracker_tb.sv
`timescale 1ns / 100ps

module midi_voice_gate_tracker_tb;
  import mvgt_pkg::*;

  localparam int NV = 32;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_item;
  logic out_valid;
  out_t out_item;

  midi_voice_gate_tracker #(.VOICES(NV)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  in_t  pending_items[$];
  out_t expected_beats[$];
  int   fail_count = 0;
  bit   stim_done = 0;

  logic [3:0]         tbl_ch[NV];
  logic [6:0]         tbl_note[NV];
  logic signed [17:0] tbl_gate[NV];
  int                 tbl_cnt;
  logic               have_root, have_third;
  logic [6:0]         root_note;
  logic               minor_third;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #300ms;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report(input string what, input out_t got, input out_t want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic out_t beat_of(logic v, logic [3:0] ch, logic [6:0] nt,
                                   logic [6:0] vel, logic ovf);
    out_t b;
    b = '0;
    b.message_valid = v;
    b.status_byte = v ? (NOTE_ON | {4'd0, ch}) : 8'd0;
    b.data_first = nt;
    b.data_second = vel;
    b.table_overflow = ovf;
    return b;
  endfunction

  task automatic drop_voice(input int k);
    for (int i = k; i + 1 < tbl_cnt; i++) begin
      tbl_ch[i] = tbl_ch[i+1];
      tbl_note[i] = tbl_note[i+1];
      tbl_gate[i] = tbl_gate[i+1];
    end
    tbl_cnt--;
  endtask

  task automatic sound_note(inout out_t bs[$], input logic [3:0] ch,
                            input logic [6:0] nt, input logic [15:0] g,
                            input logic [6:0] vel);
    for (int i = 0; i < tbl_cnt; i++) begin
      if (tbl_ch[i] == ch && tbl_note[i] == nt) begin
        bs.push_back(beat_of(1, ch, nt, 0, 0));
        drop_voice(i);
        break;
      end
    end
    if (tbl_cnt < NV) begin
      tbl_ch[tbl_cnt] = ch;
      tbl_note[tbl_cnt] = nt;
      tbl_gate[tbl_cnt] = {2'b00, g};
      tbl_cnt++;
      bs.push_back(beat_of(1, ch, nt, vel, 0));
    end else begin
      bs.push_back(beat_of(1, ch, nt, vel, 1));
    end
  endtask

  task automatic predict_beats(input in_t it);
    out_t bs[$];
    int   offs[4];
    int   cnt;
    int   i;
    int   nt;
    logic signed [17:0] g;
    if (it.operation == OP_PLAY) begin
      sound_note(bs, it.channel, it.key_number, it.gate_ticks, it.velocity);
    end else if (it.operation == OP_CHORD) begin
      offs[0] = 0;
      offs[1] = it.minor_chord ? 3 : 4;
      offs[2] = 7;
      offs[3] = 10;
      cnt = it.add_seventh ? 4 : 3;
      for (int k = 0; k < cnt; k++) begin
        nt = it.key_number + offs[k];
        if (nt <= 127) sound_note(bs, it.channel, nt[6:0], it.gate_ticks, it.velocity);
      end
    end else if (it.operation == OP_TICK) begin
      i = 0;
      while (i < tbl_cnt) begin
        g = tbl_gate[i] - $signed({2'b00, it.elapsed_ticks});
        if (g <= 0 && bs.size() < MAX_RESULTS) begin
          bs.push_back(beat_of(1, tbl_ch[i], tbl_note[i], 0, 0));
          drop_voice(i);
        end else begin
          tbl_gate[i] = (g < 0) ? 18'sd0 : g;
          i++;
        end
      end
      have_root = 0;
      have_third = 0;
      root_note = 0;
      minor_third = 0;
      for (int a = 0; a < tbl_cnt; a++)
        for (int b = 0; b < tbl_cnt; b++) begin
          if (tbl_note[b] > tbl_note[a]) begin
            case ((tbl_note[b] - tbl_note[a]) % 12)
              3: begin have_third = 1; minor_third = 1; end
              4: begin have_third = 1; minor_third = 0; end
              7: begin have_root = 1; root_note = tbl_note[a]; end
              default: ;
            endcase
          end
        end
    end
    if (bs.size() == 0) bs.push_back(beat_of(0, 0, 0, 0, 0));
    foreach (bs[k]) begin
      bs[k].chord_root = have_root ? root_note : 7'd0;
      bs[k].root_found = have_root;
      bs[k].chord_is_minor = have_third ? minor_third : 1'b0;
      bs[k].quality_found = have_third;
      bs[k].last_result = (k == bs.size() - 1);
      expected_beats.push_back(bs[k]);
    end
  endtask

  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 0;
    end else begin
      if (start && !busy) begin
        predict_beats(in_item);
        void'(pending_items.pop_front());
        gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
                                               : $urandom_range(0, 3);
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 0;
      end else if (pending_items.size() > 0) begin
        start <= 1;
        in_item <= pending_items[0];
      end else begin
        start <= 0;
      end
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (expected_beats.size() == 0) begin
        report("unexpected beat", out_item, '0);
      end else begin
        want = expected_beats.pop_front();
        if (out_item.message_valid !== want.message_valid) report("message_valid", out_item, want);
        if (out_item.status_byte !== want.status_byte) report("status_byte", out_item, want);
        if (out_item.data_first !== want.data_first) report("data_first", out_item, want);
        if (out_item.data_second !== want.data_second) report("data_second", out_item, want);
        if (out_item.chord_root !== want.chord_root) report("chord_root", out_item, want);
        if (out_item.root_found !== want.root_found) report("root_found", out_item, want);
        if (out_item.chord_is_minor !== want.chord_is_minor)
          report("chord_is_minor", out_item, want);
        if (out_item.quality_found !== want.quality_found) report("quality_found", out_item, want);
        if (out_item.table_overflow !== want.table_overflow)
          report("table_overflow", out_item, want);
        if (out_item.last_result !== want.last_result) report("last_result", out_item, want);
      end
    end
  end

  function automatic in_t mk(logic [1:0] op, logic [3:0] ch, logic [6:0] key,
                             logic [15:0] g, logic [6:0] vel, logic mn,
                             logic sv, logic [15:0] el);
    in_t it;
    it.operation = op;
    it.channel = ch;
    it.key_number = key;
    it.gate_ticks = g;
    it.velocity = vel;
    it.minor_chord = mn;
    it.add_seventh = sv;
    it.elapsed_ticks = el;
    return it;
  endfunction

  function automatic in_t rand_item();
    in_t it;
    int  r;
    it = in_t'({$urandom, $urandom});
    r = $urandom_range(0, 99);
    if (r < 40) it.operation = OP_PLAY;
    else if (r < 65) it.operation = OP_CHORD;
    else if (r < 95) it.operation = OP_TICK;
    else it.operation = 2'd3;
    if ($urandom_range(0, 3) != 0) it.channel = $urandom_range(0, 2);
    if ($urandom_range(0, 2) != 0) it.key_number = $urandom_range(48, 72);
    if ($urandom_range(0, 3) != 0) it.gate_ticks = $urandom_range(0, 400);
    if ($urandom_range(0, 3) != 0) it.elapsed_ticks = $urandom_range(0, 150);
    return it;
  endfunction

  initial begin
    rst_n = 0;
    start = 0;
    in_item = '0;
    tbl_cnt = 0;
    have_root = 0;
    have_third = 0;
    root_note = 0;
    minor_third = 0;
    foreach (tbl_ch[i]) begin
      tbl_ch[i] = 0;
      tbl_note[i] = 0;
      tbl_gate[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1;

    pending_items.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(2'd3, 15, 127, 16'hFFFF, 127, 1, 1, 16'hFFFF));
    pending_items.push_back(mk(OP_PLAY, 0, 0, 0, 127, 0, 0, 0));
    pending_items.push_back(mk(OP_PLAY, 15, 127, 16'hFFFF, 1, 0, 0, 0));
    pending_items.push_back(mk(OP_PLAY, 15, 127, 16'hFFFF, 0, 0, 0, 0));
    pending_items.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(OP_CHORD, 3, 60, 100, 90, 0, 1, 0));
    pending_items.push_back(mk(OP_CHORD, 4, 57, 100, 90, 1, 0, 0));
    pending_items.push_back(mk(OP_CHORD, 5, 125, 100, 90, 1, 1, 0));
    pending_items.push_back(mk(OP_CHORD, 5, 127, 100, 90, 0, 1, 0));
    pending_items.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 50));
    pending_items.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 16'hFFFF));
    for (int i = 0; i < 9; i++)
      pending_items.push_back(mk(OP_CHORD, i[3:0], 7'(i * 5), 16'hFFFF, 64, i[0], 1, 0));
    pending_items.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 1));
    pending_items.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 16'hFFFF));
    for (int i = 0; i < 205; i++) pending_items.push_back(rand_item());
    pending_items.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 16'hFFFF));
    pending_items.push_back(mk(OP_TICK, 0, 0, 0, 0, 0, 0, 16'hFFFF));

    wait (pending_items.size() == 0);
    wait (expected_beats.size() == 0);
    repeat (3000) @(posedge clk);
    if (fail_count == 0 && expected_beats.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
